FILE: sv/gww_pkg.sv
// Shared types and constants for the greedy word wrap block.
package gww_pkg;

  localparam int unsigned CfgW = 6;
  localparam logic [CfgW-1:0] LineWidthRst = 6'd32;
  localparam logic [7:0] SpaceChar = 8'h20;

  localparam logic KindChar  = 1'b0;
  localparam logic KindBreak = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_PBRK,
    S_SWORD,
    S_SBRK,
    S_STORE,
    S_FIN,
    S_FBRK,
    S_FSPC,
    S_FWORD,
    S_FSBRK,
    S_END,
    S_DONE
  } state_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       last;
    logic       done;
  } item_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == SpaceChar) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

FILE: sv/greedy_word_wrap.sv
// Top level: greedy word wrap over a byte stream, one word buffer replayed per line.
// Throughput: one item at a time; a new item is accepted only once the block is back
// in idle, and the sequencer emits one result per cycle from the word buffer while
// the result side is ready.
// Reset: control state and the open line clear, line width becomes 32; the word
// buffer is not cleared.
module greedy_word_wrap #(
  parameter int unsigned WordMax = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i,     // line_width
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // end_of_text
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] char_out
  output logic [1:0]  m_axis_tuser,   // [0] item_kind, [1] text_done
  output logic        m_axis_tlast    // run_last
);

  localparam int unsigned AW = (WordMax > 1) ? $clog2(WordMax) : 1;
  localparam int unsigned CW = $clog2(WordMax + 1);
  localparam logic [gww_pkg::CfgW-1:0] MaxW = gww_pkg::CfgW'(WordMax);

  gww_pkg::state_e state_q, state_d;
  logic [CW-1:0]   wc_q, wc_d;
  logic [CW-1:0]   lc_q, lc_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            split_q, split_d;
  logic [7:0]      c_q, c_d;
  logic            end_q, end_d;
  logic            ws_q, ws_d;
  logic [gww_pkg::CfgW-1:0] lw_q, lw_d;
  gww_pkg::item_t  hold_q, hold_d;
  logic            hold_v_q, hold_v_d;
  gww_pkg::item_t  out_q, out_d;
  logic            out_v_q, out_v_d;

  logic [gww_pkg::CfgW-1:0] w_clamp;
  logic [CW-1:0]   w_eff;
  logic [CW:0]     fit_sum;
  logic            out_free;
  logic            can_emit;
  logic            emit;
  gww_pkg::item_t  new_item;
  logic            buf_we;
  logic [7:0]      rd_data;

  assign w_clamp = (lw_q == '0) ? gww_pkg::CfgW'(1) : ((lw_q > MaxW) ? MaxW : lw_q);
  assign w_eff   = w_clamp[CW-1:0];
  assign fit_sum = {1'b0, lc_q} + {1'b0, wc_q} + (CW+1)'(1);
  assign out_free = !out_v_q || m_axis_tready;
  assign can_emit = !hold_v_q || out_free;

  assign cfg_ready_o   = (state_q == gww_pkg::S_IDLE);
  assign s_axis_tready = (state_q == gww_pkg::S_IDLE) && !cfg_valid_i;
  assign buf_we        = (state_q == gww_pkg::S_STORE) && (wc_q < CW'(WordMax));

  gww_buf #(
    .Depth (WordMax),
    .AW    (AW)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (wc_q[AW-1:0]),
    .wdata_i (c_q),
    .raddr_i (idx_d[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d  = state_q;
    wc_d     = wc_q;
    lc_d     = lc_q;
    idx_d    = '0;
    split_d  = split_q;
    c_d      = c_q;
    end_d    = end_q;
    ws_d     = ws_q;
    lw_d     = lw_q;
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q;
    emit     = 1'b0;
    new_item = '{kind: gww_pkg::KindBreak, ch: 8'h00, last: 1'b0, done: 1'b0};

    if (out_v_q && m_axis_tready) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      gww_pkg::S_IDLE: begin
        if (cfg_valid_i) begin
          lw_d    = cfg_data_i;
          wc_d    = '0;
          lc_d    = '0;
          split_d = 1'b0;
        end else if (s_axis_tvalid) begin
          c_d     = s_axis_tdata;
          end_d   = s_axis_tlast;
          ws_d    = gww_pkg::is_space(s_axis_tdata);
          state_d = gww_pkg::S_CHK;
        end
      end
      gww_pkg::S_CHK: begin
        if (ws_q) begin
          state_d = gww_pkg::S_FIN;
        end else if (wc_q >= w_eff) begin
          state_d = (!split_q && lc_q != '0) ? gww_pkg::S_PBRK : gww_pkg::S_SWORD;
        end else begin
          state_d = gww_pkg::S_STORE;
        end
      end
      gww_pkg::S_PBRK: begin
        if (can_emit) begin
          emit    = 1'b1;
          lc_d    = '0;
          state_d = gww_pkg::S_SWORD;
        end
      end
      gww_pkg::S_SWORD: begin
        idx_d = idx_q;
        if (idx_q == wc_q) begin
          idx_d   = '0;
          state_d = gww_pkg::S_SBRK;
        end else if (can_emit) begin
          emit     = 1'b1;
          new_item = '{kind: gww_pkg::KindChar, ch: rd_data, last: 1'b0, done: 1'b0};
          idx_d    = idx_q + CW'(1);
        end
      end
      gww_pkg::S_SBRK: begin
        if (can_emit) begin
          emit    = 1'b1;
          split_d = 1'b1;
          wc_d    = '0;
          state_d = gww_pkg::S_STORE;
        end
      end
      gww_pkg::S_STORE: begin
        if (wc_q < CW'(WordMax)) begin
          wc_d = wc_q + CW'(1);
        end
        state_d = end_q ? gww_pkg::S_FIN : gww_pkg::S_DONE;
      end
      gww_pkg::S_FIN: begin
        if (wc_q == '0) begin
          split_d = 1'b0;
          state_d = gww_pkg::S_END;
        end else if (split_q) begin
          state_d = gww_pkg::S_FWORD;
        end else if (lc_q != '0 && fit_sum > {1'b0, w_eff}) begin
          state_d = gww_pkg::S_FBRK;
        end else if (lc_q != '0) begin
          state_d = gww_pkg::S_FSPC;
        end else begin
          state_d = gww_pkg::S_FWORD;
        end
      end
      gww_pkg::S_FBRK: begin
        if (can_emit) begin
          emit    = 1'b1;
          lc_d    = '0;
          state_d = gww_pkg::S_FWORD;
        end
      end
      gww_pkg::S_FSPC: begin
        if (can_emit) begin
          emit     = 1'b1;
          new_item = '{kind: gww_pkg::KindChar, ch: gww_pkg::SpaceChar, last: 1'b0,
                       done: 1'b0};
          lc_d     = lc_q + CW'(1);
          state_d  = gww_pkg::S_FWORD;
        end
      end
      gww_pkg::S_FWORD: begin
        idx_d = idx_q;
        if (idx_q == wc_q) begin
          idx_d = '0;
          if (split_q) begin
            state_d = gww_pkg::S_FSBRK;
          end else begin
            lc_d    = lc_q + wc_q;
            wc_d    = '0;
            state_d = gww_pkg::S_END;
          end
        end else if (can_emit) begin
          emit     = 1'b1;
          new_item = '{kind: gww_pkg::KindChar, ch: rd_data, last: 1'b0, done: 1'b0};
          idx_d    = idx_q + CW'(1);
        end
      end
      gww_pkg::S_FSBRK: begin
        if (can_emit) begin
          emit    = 1'b1;
          lc_d    = '0;
          split_d = 1'b0;
          wc_d    = '0;
          state_d = gww_pkg::S_END;
        end
      end
      gww_pkg::S_END: begin
        if (!end_q) begin
          state_d = gww_pkg::S_DONE;
        end else if (lc_q == '0) begin
          split_d = 1'b0;
          wc_d    = '0;
          state_d = gww_pkg::S_DONE;
        end else if (can_emit) begin
          emit    = 1'b1;
          lc_d    = '0;
          split_d = 1'b0;
          wc_d    = '0;
          state_d = gww_pkg::S_DONE;
        end
      end
      gww_pkg::S_DONE: begin
        if (!hold_v_q) begin
          state_d = gww_pkg::S_IDLE;
        end else if (out_free) begin
          out_d      = hold_q;
          out_d.last = 1'b1;
          out_d.done = end_q && (hold_q.kind == gww_pkg::KindBreak);
          out_v_d    = 1'b1;
          hold_v_d   = 1'b0;
          state_d    = gww_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gww_pkg::S_IDLE;
      end
    endcase

    if (emit) begin
      if (hold_v_q) begin
        out_d   = hold_q;
        out_v_d = 1'b1;
      end
      hold_d   = new_item;
      hold_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gww_pkg::S_IDLE;
      wc_q     <= '0;
      lc_q     <= '0;
      idx_q    <= '0;
      split_q  <= 1'b0;
      lw_q     <= gww_pkg::LineWidthRst;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      wc_q     <= wc_d;
      lc_q     <= lc_d;
      idx_q    <= idx_d;
      split_q  <= split_d;
      lw_q     <= lw_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    end_q  <= end_d;
    ws_q   <= ws_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = out_q.ch;
  assign m_axis_tuser[0] = out_q.kind;
  assign m_axis_tuser[1] = out_q.done;
  assign m_axis_tlast    = out_q.last;

  a_done_is_last_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && m_axis_tlast)
    else $error("text_done on an item that is not the final line break");

  a_break_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
    else $error("line break carries a character");

  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !hold_v_q)
    else $error("accepting an item while a result is still held back");

  a_line_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gww_pkg::S_IDLE && $past(state_q) == gww_pkg::S_DONE |-> lc_q <= w_eff)
    else $error("open line is longer than the line width");

  a_word_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= CW'(WordMax))
    else $error("word count beyond the buffer depth");

endmodule

FILE: sv/gww_buf.sv
// Word buffer: one write port, one registered read port with write forwarding.
module gww_buf #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
